[hw/rtl/ise_pkg.sv]
package ise_pkg;

  localparam int ISE_DEPTH = 64;
  localparam int ISE_W     = 32;

  typedef struct packed {
    logic signed [ISE_W-1:0] value;
    logic                    is_last;
  } ise_in_t;

  typedef struct packed {
    logic signed [ISE_W-1:0] sorted_value;
    logic                    is_final;
    logic                    overflow;
  } ise_out_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                    vld;
    logic                    gt;
    logic signed [ISE_W-1:0] val;
  } ise_link_t;

endpackage

[hw/rtl/ise_cell.sv]
module ise_cell
  import ise_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ins,
  input  logic                    shift,
  input  logic signed [ISE_W-1:0] x,
  input  ise_link_t               left,
  input  ise_link_t               right,
  output ise_link_t               self
);

  logic                    vld_r;
  logic                    vld_nxt;
  logic signed [ISE_W-1:0] val_r;
  logic signed [ISE_W-1:0] val_nxt;
  logic                    gt;

  // an empty cell counts as larger than any value; strict compare keeps
  // equal values in arrival order
  assign gt = !vld_r || (val_r > x);

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (shift) begin
      vld_nxt = right.vld;
      val_nxt = right.val;
    end else if (ins && gt) begin
      if (left.gt) begin
        vld_nxt = left.vld;
        val_nxt = left.val;
      end else begin
        vld_nxt = 1'b1;
        val_nxt = x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign self.vld = vld_r;
  assign self.gt  = gt;
  assign self.val = val_r;

endmodule

[hw/rtl/integer_sort_engine.sv]
// Stable ascending sorter for sets of signed 32-bit values. Send one value per
// cycle with start while busy is low; the value is inserted into a chain of
// DEPTH compare-and-shift cells in the cycle it is taken. The item marked
// is_last closes the set: busy then rises and the chain shifts its contents
// out toward the output, one result per cycle (n results, n = stored count),
// with out_strobe high for exactly one cycle per result and is_final on the
// last. The receiver cannot stall, so results must be taken as they appear.
// Values beyond DEPTH are dropped and every result of that set carries
// overflow. A set occupies the block while its items are sent and while it
// drains with busy high; each result is captured into the output register as
// the chain shifts it out.
module integer_sort_engine
  import ise_pkg::*;
#(
  parameter int DEPTH = ISE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ise_in_t  in_data,
  output logic     out_strobe,
  output ise_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          dropped_r, dropped_nxt;
  logic          strobe_r, strobe_nxt;
  ise_out_t      out_r, out_nxt;

  logic      accept;
  logic      full;
  logic      ins;
  logic      shift;
  ise_link_t links [DEPTH];
  ise_link_t edge_left;
  ise_link_t edge_right;

  assign busy   = (state_r == ST_DRAIN);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign ins    = accept && !full;
  assign shift  = busy;

  assign edge_left  = '{vld: 1'b0, gt: 1'b0, val: '0};
  assign edge_right = '{vld: 1'b0, gt: 1'b1, val: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ise_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ins   (ins),
      .shift (shift),
      .x     (in_data.value),
      .left  ((i == 0) ? edge_left : links[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? edge_right : links[(i == DEPTH - 1) ? i : i + 1]),
      .self  (links[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    dropped_nxt = dropped_r;
    strobe_nxt  = 1'b0;
    out_nxt     = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_data.is_last) begin
            state_nxt = ST_DRAIN;
            rem_nxt   = count_nxt;
          end
        end
      end
      ST_DRAIN: begin
        // transfer the head cell out while the chain advances
        strobe_nxt           = 1'b1;
        out_nxt.sorted_value = links[0].val;
        out_nxt.is_final     = (rem_r == CW'(1));
        out_nxt.overflow     = dropped_r;
        rem_nxt              = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt   = ST_IDLE;
          count_nxt   = '0;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rem_r     <= '0;
      dropped_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rem_r     <= rem_nxt;
      dropped_r <= dropped_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

[tb/integer_sort_engine_test.sv]
module integer_sort_engine_test;
  import ise_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = ISE_DEPTH + 8;
  localparam int IDLE_PCT    = 8;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ise_in_t  in_data = '0;
  logic     out_strobe;
  ise_out_t out_data;

  // predictor state: the set being collected and its overflow mark
  logic signed [ISE_W-1:0] held_values[$];
  logic                    held_dropped = 1'b0;
  ise_out_t                expected_sorted[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  integer_sort_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [ISE_W-1:0] got,
                                 input logic [ISE_W-1:0] want);
    $display("MISMATCH %s: got 0x%08h want 0x%08h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Stable insertion sort of the held set, queued as expected results.
  function automatic void emit_sorted_set();
    logic signed [ISE_W-1:0] ordered[$];
    logic signed [ISE_W-1:0] v;
    ise_out_t                r;
    int                      i;
    int                      j;
    ordered = held_values;
    for (i = 1; i < ordered.size(); i++) begin
      v = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    for (i = 0; i < ordered.size(); i++) begin
      r.sorted_value = ordered[i];
      r.is_final     = (i == ordered.size() - 1);
      r.overflow     = held_dropped;
      expected_sorted.push_back(r);
    end
    held_values.delete();
    held_dropped = 1'b0;
  endfunction

  function automatic void absorb_value(input ise_in_t it);
    if (held_values.size() < ISE_DEPTH) begin
      held_values.push_back(it.value);
    end else begin
      held_dropped = 1'b1;
    end
    if (it.is_last) begin
      emit_sorted_set();
    end
  endfunction

  // Hold start high across back-to-back transfers; lower it only to idle.
  task automatic send_item(input logic signed [ISE_W-1:0] value, input logic is_last);
    ise_in_t it;
    it.value   = value;
    it.is_last = is_last;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_value(it);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_sorted.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [ISE_W-1:0] pick_value();
    case ($urandom_range(4))
      0: pick_value = $signed($urandom_range(6)) - 3;
      1: pick_value = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: pick_value = $signed($urandom_range(255)) - 128;
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic send_set(input int size);
    int k;
    for (k = 0; k < size; k++) begin
      send_item(pick_value(), k == size - 1);
    end
  endtask

  task automatic test_extremes();
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(32'sh00000000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh55aaaa55, 1'b1);
  endtask

  task automatic test_single_item_sets();
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh7fffffff, 1'b1);
  endtask

  task automatic test_equal_values();
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd3, 1'b1);
  endtask

  task automatic test_descending();
    int k;
    for (k = 0; k < 8; k++) begin
      send_item(32'sd1000 - k * 300, k == 7);
    end
  endtask

  // Fill the chain with no idle cycles between transfers.
  task automatic test_full_set();
    steady = 1'b1;
    send_set(ISE_DEPTH);
    steady = 1'b0;
  endtask

  // Items past capacity are dropped, including the marked one.
  task automatic test_overflow();
    send_set(ISE_DEPTH + 2);
  endtask

  task automatic test_random_sets();
    int sent;
    int set_index;
    int size;
    sent = 0;
    set_index = 0;
    while (sent < 20) begin
      steady = (set_index >= 3 && set_index < 7);
      size = $urandom_range(1, 4);
      send_set(size);
      sent += size;
      set_index++;
      if (set_index == 5) begin
        wait_drain();
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    ise_out_t want;
    if (rst_n && out_strobe) begin
      if (expected_sorted.size() == 0) begin
        report_mismatch("unexpected result", out_data.sorted_value, '0);
      end else begin
        want = expected_sorted.pop_front();
        if (out_data.sorted_value !== want.sorted_value)
          report_mismatch("sorted_value", out_data.sorted_value, want.sorted_value);
        if (out_data.is_final !== want.is_final)
          report_mismatch("is_final", ISE_W'(out_data.is_final), ISE_W'(want.is_final));
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", ISE_W'(out_data.overflow), ISE_W'(want.overflow));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_single_item_sets();
    test_equal_values();
    test_descending();
    test_full_set();
    test_overflow();
    test_random_sets();
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_sorted.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ise_pkg.sv
hw/rtl/ise_cell.sv
hw/rtl/integer_sort_engine.sv
tb/integer_sort_engine_test.sv
